FILE: hw/rtl/block_bitmap_allocator_unit_macros.svh
// Assertion macros shared by the bitmap allocator RTL.
`ifndef BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The expression must hold in every cycle outside reset.
`define BBA_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`endif

FILE: hw/rtl/bba_pkg.sv
// Types and constants of the bitmap block allocator.
`timescale 1ns / 1ps

package bba_pkg;

   localparam int WORD_BITS = 64;
   localparam int BIT_IDX_W = 6;
   localparam int BLOCK_W   = 12;
   localparam int COUNT_W   = 13;
   localparam int STATUS_W  = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 13'd4096;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FREE_CHK,
      ST_DONE
   } state_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_FULL         = 2'd1,
      STATUS_ALREADY_FREE = 2'd2,
      STATUS_RANGE        = 2'd3
   } status_type;

endpackage

FILE: hw/rtl/block_bitmap_allocator_unit.sv
// Allocate: the scan reads one 64-bit bitmap word per cycle from word zero up to a
// free bit or the last word below the limit, then the result is ready.
// Free: a check state tests the bit. A zero-limit allocate or an out-of-range free
// skips to the result. The next item is accepted only after a result is loaded.
// The bitmap sits in one single-port-read, single-port-write memory of 64-bit words.
// Synchronous reset: clear one word per cycle, no item taken; block_count resets to 4096.
`timescale 1ns / 1ps

module block_bitmap_allocator_unit #(
   parameter int MAX_BLOCKS = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_operation,
   input  logic [bba_pkg::BLOCK_W-1:0]      req_block_number,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bba_pkg::BLOCK_W-1:0]      rsp_allocated_block,
   output logic [bba_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bba_pkg::COUNT_W-1:0]      rsp_used_blocks,
   input  logic                             csr_wr_en,
   input  logic [bba_pkg::COUNT_W-1:0]      csr_wr_data
);

   import bba_pkg::*;

   localparam int WordCount = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int AddrW     = (WordCount > 1) ? $clog2(WordCount) : 1;
   localparam int CountW    = $clog2(MAX_BLOCKS + 1);
   localparam int CountMax  = (1 << COUNT_W) - 1;
   localparam int LimitCap  = (MAX_BLOCKS > CountMax) ? CountMax : MAX_BLOCKS;
   localparam logic [AddrW-1:0] LastAddr = AddrW'(WordCount - 1);

   // Control state.
   state_type                state_ff, state_in;
   logic [COUNT_W-1:0]       block_count_ff;
   logic [AddrW-1:0]         clr_addr_ff;
   logic [CountW-1:0]        used_count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Item payload.
   logic                     op_ff;
   logic [BLOCK_W-1:0]       bn_ff;
   logic [AddrW-1:0]         rd_addr_ff;
   word_type                 rd_data_ff;
   status_type               res_status_ff;
   logic [BLOCK_W-1:0]       res_block_ff;
   word_type                 res_word_ff;
   logic [BLOCK_W-1:0]       rsp_block_ff;
   status_type               rsp_status_ff;
   logic [COUNT_W-1:0]       rsp_used_ff;

   word_type                 bitmap_mem [WordCount];

   // Memory port controls.
   logic                     mem_rd_en;
   logic [AddrW-1:0]         mem_rd_addr;
   logic                     mem_wr_en;
   logic [AddrW-1:0]         mem_wr_addr;
   word_type                 mem_wr_data;

   logic                     req_accept;
   logic                     rsp_load;
   logic                     can_load;

   logic [COUNT_W-1:0]       limit;
   logic [COUNT_W-1:0]       limit_m1;
   logic [COUNT_W-BIT_IDX_W-1:0] last_word;
   word_type                 tail_mask;
   logic                     at_last;
   word_type                 free_bits;
   logic                     found;
   logic [BIT_IDX_W-1:0]     first_pos;
   word_type                 alloc_word;
   logic [31:0]              given_ext;
   logic                     bit_set;
   word_type                 free_word;
   logic [31:0]              bn_word_ext;
   logic [AddrW-1:0]         bn_addr;
   logic                     bn_out_of_range;
   logic [AddrW-1:0]         next_addr;
   logic [31:0]              count_ext;

   // Effective limit and the valid bits of the last word below it.
   assign limit     = (block_count_ff > COUNT_W'(LimitCap)) ? COUNT_W'(LimitCap)
                                                          : block_count_ff;
   assign limit_m1  = limit - COUNT_W'(1);
   assign last_word = limit_m1[COUNT_W-1:BIT_IDX_W];
   assign tail_mask = {WORD_BITS{1'b1}} >>
                      (BIT_IDX_W'(WORD_BITS - 1) - limit_m1[BIT_IDX_W-1:0]);
   assign at_last   = (32'(rd_addr_ff) == 32'(last_word));

   // First free bit of the word under inspection.
   assign free_bits = ~rd_data_ff & (at_last ? tail_mask : {WORD_BITS{1'b1}});
   assign found     = |free_bits;

   always_comb begin
      first_pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            first_pos = BIT_IDX_W'(i);
         end
      end
   end

   assign alloc_word = rd_data_ff | (word_type'(1) << first_pos);
   assign given_ext  = 32'({rd_addr_ff, first_pos});
   assign bit_set    = rd_data_ff[bn_ff[BIT_IDX_W-1:0]];
   assign free_word  = rd_data_ff & ~(word_type'(1) << bn_ff[BIT_IDX_W-1:0]);

   assign bn_word_ext     = 32'(req_block_number) >> BIT_IDX_W;
   assign bn_addr         = bn_word_ext[AddrW-1:0];
   assign bn_out_of_range = (COUNT_W'(req_block_number) >= limit);
   assign next_addr       = rd_addr_ff + AddrW'(1);

   assign req_accept = req_valid && !req_stall;
   assign can_load   = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == LastAddr) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_ALLOC) begin
                  state_in = (limit == '0) ? ST_DONE : ST_SCAN;
               end else begin
                  state_in = bn_out_of_range ? ST_DONE : ST_FREE_CHK;
               end
            end
         end
         ST_SCAN: begin
            if (found || at_last) begin
               state_in = ST_DONE;
            end
         end
         ST_FREE_CHK: state_in = ST_DONE;
         ST_DONE: begin
            if (can_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      req_stall   = 1'b1;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = rd_addr_ff;
      mem_wr_data = res_word_ff;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = '0;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            mem_rd_en = req_valid;
            // An allocate starts at word zero; an out-of-range free reads nothing useful.
            if (req_operation == OP_FREE && !bn_out_of_range) begin
               mem_rd_addr = bn_addr;
            end
         end
         ST_SCAN: begin
            mem_rd_en   = !at_last && !found;
            mem_rd_addr = next_addr;
         end
         ST_FREE_CHK: begin
            mem_rd_en = 1'b0;
         end
         ST_DONE: begin
            rsp_load  = can_load;
            mem_wr_en = can_load && (res_status_ff == STATUS_OK);
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Used count after the finishing item.
   always_comb begin
      count_in = used_count_ff;
      if (res_status_ff == STATUS_OK) begin
         if (op_ff == OP_ALLOC) begin
            count_in = used_count_ff + CountW'(1);
         end else if (used_count_ff != '0) begin
            count_in = used_count_ff - CountW'(1);
         end
      end
   end

   assign count_ext    = 32'(count_in);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         block_count_ff <= BLOCK_COUNT_RESET;
         clr_addr_ff    <= '0;
         used_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            block_count_ff <= csr_wr_data;
         end
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + AddrW'(1);
         end
         if (rsp_load) begin
            used_count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff         <= req_operation;
         bn_ff         <= req_block_number;
         res_block_ff  <= '0;
         res_status_ff <= (req_operation == OP_ALLOC) ? STATUS_FULL : STATUS_RANGE;
      end
      if (state_ff == ST_SCAN && found) begin
         res_status_ff <= STATUS_OK;
         res_block_ff  <= given_ext[BLOCK_W-1:0];
         res_word_ff   <= alloc_word;
      end
      if (state_ff == ST_FREE_CHK) begin
         res_status_ff <= bit_set ? STATUS_OK : STATUS_ALREADY_FREE;
         res_word_ff   <= free_word;
      end
      if (rsp_load) begin
         rsp_block_ff  <= res_block_ff;
         rsp_status_ff <= res_status_ff;
         rsp_used_ff   <= count_ext[COUNT_W-1:0];
      end
   end

   // Bitmap memory: one write port, one read port with registered data.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         bitmap_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_addr_ff <= mem_rd_addr;
         rd_data_ff <= bitmap_mem[mem_rd_addr];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_allocated_block = rsp_block_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_used_blocks     = rsp_used_ff;

   `include "block_bitmap_allocator_unit_macros.svh"

   `BBA_ASSERT_IMPLY(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DONE), "result appeared without a finished item")
   `BBA_ASSERT_ALWAYS(a_count_bound, clock, reset, 32'(used_count_ff) <= 32'(MAX_BLOCKS), "used count exceeds the bitmap size")
   `BBA_ASSERT_IMPLY(a_scan_bound, clock, reset, state_ff == ST_SCAN, 32'(rd_addr_ff) <= 32'(last_word), "scan ran past the last word below the limit")
   `BBA_ASSERT_IMPLY(a_alloc_in_limit, clock, reset, rsp_load && op_ff == OP_ALLOC && res_status_ff == STATUS_OK, 32'(res_block_ff) < 32'(limit), "allocated block lies beyond the limit")
   `BBA_ASSERT_IMPLY(a_block_zero_on_error, clock, reset, rsp_valid_ff && rsp_status_ff != STATUS_OK, rsp_block_ff == '0, "failed item carries a block number")

endmodule

FILE: tb/block_bitmap_allocator_unit_test.sv
// Self-checking testbench for the first-fit bitmap block allocator.
`timescale 1ns / 1ps

module block_bitmap_allocator_unit_test;
   import bba_pkg::*;

   localparam int NUM_BLOCKS      = 4096;
   localparam int IDLE_PCT        = 27;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 70;
   localparam int WATCHDOG_CYCLES = 4000;
   localparam int MAX_REPORTS     = 60;

   typedef struct packed {
      logic [BLOCK_W-1:0] block;
      status_type         status;
      logic [COUNT_W-1:0] used;
   } outcome_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic                req_operation    = OP_ALLOC;
   logic [BLOCK_W-1:0]  req_block_number = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [BLOCK_W-1:0]  rsp_allocated_block;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_used_blocks;
   logic                csr_wr_en        = 1'b0;
   logic [COUNT_W-1:0]  csr_wr_data      = '0;

   // Shadow copy of the allocator state.
   bit                 block_busy [NUM_BLOCKS];
   logic [COUNT_W-1:0] busy_total;
   logic [COUNT_W-1:0] managed_blocks;

   outcome_type outcomes_due[$];
   outcome_type arrived_due;

   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   int fail_count     = 0;
   int items_sent     = 0;
   int settings_used  = 0;
   int idle_cycles    = 0;
   int status_seen [4];

   block_bitmap_allocator_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_block_number    (req_block_number),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_allocated_block (rsp_allocated_block),
      .rsp_status          (rsp_status),
      .rsp_used_blocks     (rsp_used_blocks),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int effective_limit();
      return (int'(managed_blocks) > NUM_BLOCKS) ? NUM_BLOCKS : int'(managed_blocks);
   endfunction

   // Computes the reply to one request and updates the shadow state.
   function automatic outcome_type apply_block_request(logic op, logic [BLOCK_W-1:0] bn);
      outcome_type reply;
      int          lim;
      lim          = effective_limit();
      reply.block  = '0;
      if (op == OP_ALLOC) begin
         reply.status = STATUS_FULL;
         for (int b = 0; b < lim; b++) begin
            if (!block_busy[b]) begin
               block_busy[b] = 1'b1;
               busy_total    = busy_total + COUNT_W'(1);
               reply.block   = b[BLOCK_W-1:0];
               reply.status  = STATUS_OK;
               break;
            end
         end
      end else if (int'(bn) >= lim) begin
         reply.status = STATUS_RANGE;
      end else if (!block_busy[bn]) begin
         reply.status = STATUS_ALREADY_FREE;
      end else begin
         block_busy[bn] = 1'b0;
         if (busy_total != '0) busy_total = busy_total - COUNT_W'(1);
         reply.status = STATUS_OK;
      end
      reply.used = busy_total;
      return reply;
   endfunction

   // Returns a random in-use block below the limit, or -1 if there is none.
   function automatic int busy_block_pick();
      int lim;
      int n;
      int k;
      lim = effective_limit();
      n   = 0;
      for (int b = 0; b < lim; b++) n += int'(block_busy[b]);
      if (n == 0) return -1;
      k = $urandom_range(0, n - 1);
      for (int b = 0; b < lim; b++) begin
         if (block_busy[b]) begin
            if (k == 0) return b;
            k--;
         end
      end
      return -1;
   endfunction

   task automatic compare_field(input string what, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         if (fail_count < MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fail_count++;
      end
   endtask

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         status_seen[rsp_status]++;
         if (outcomes_due.size() == 0) begin
            $display("%0t ns: result with none expected, expected nothing, actual block %0d status %0d used %0d",
                     $time, rsp_allocated_block, rsp_status, rsp_used_blocks);
            fail_count++;
         end else begin
            arrived_due = outcomes_due.pop_front();
            compare_field("allocated_block", 32'(arrived_due.block), 32'(rsp_allocated_block));
            compare_field("status", 32'(arrived_due.status), 32'(rsp_status));
            compare_field("used_blocks", 32'(arrived_due.used), 32'(rsp_used_blocks));
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= receiver_idles && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // Ends the run if neither channel moves an item for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t ns: no item moved for %0d cycles", $time, idle_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   // Valid is left high so that the next item can follow without a gap.
   task automatic send_item(input logic op, input logic [BLOCK_W-1:0] bn);
      while (sender_idles && ($urandom_range(0, 99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_block_number <= bn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      outcomes_due.push_back(apply_block_request(op, bn));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      while (outcomes_due.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic set_block_count(input logic [COUNT_W-1:0] value);
      wait_idle(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en      <= 1'b0;
      managed_blocks  = value;
      settings_used++;
   endtask

   // Mostly allocations and frees of blocks that are in use, plus some noise.
   task automatic run_random(input int items, input int alloc_pct);
      int roll;
      int pick;
      int lim;
      for (int i = 0; i < items; i++) begin
         roll = $urandom_range(0, 99);
         pick = busy_block_pick();
         lim  = effective_limit();
         if (roll < alloc_pct)
            send_item(OP_ALLOC, BLOCK_W'($urandom_range(0, NUM_BLOCKS - 1)));
         else if (roll < 90 && pick >= 0)
            send_item(OP_FREE, BLOCK_W'(pick));
         else if (roll < 95 && lim > 0)
            send_item(OP_FREE, BLOCK_W'($urandom_range(0, lim - 1)));
         else
            send_item(OP_FREE, BLOCK_W'($urandom_range(0, NUM_BLOCKS - 1)));
      end
   endtask

   task automatic test_directed_edges();
      send_item(OP_FREE, 12'd0);
      send_item(OP_FREE, 12'd4095);
      send_item(OP_ALLOC, 12'd4095);
      send_item(OP_ALLOC, 12'd0);
      send_item(OP_FREE, 12'd1);
      send_item(OP_FREE, 12'd1);
      send_item(OP_ALLOC, 12'hAAA);
      send_item(OP_FREE, 12'd2048);
      // A zero count makes every free out of range and every allocate fail.
      set_block_count(13'd0);
      send_item(OP_ALLOC, 12'd0);
      send_item(OP_FREE, 12'd0);
      // Block 1 stays in use but now lies beyond the limit.
      set_block_count(13'd1);
      send_item(OP_ALLOC, 12'd0);
      send_item(OP_FREE, 12'd1);
      send_item(OP_FREE, 12'd0);
      send_item(OP_ALLOC, 12'h555);
      send_item(OP_ALLOC, 12'd0);
      // The largest count acts as the full bitmap size.
      set_block_count(13'd8191);
      send_item(OP_FREE, 12'd4095);
      send_item(OP_ALLOC, 12'd0);
      send_item(OP_FREE, 12'd2);
      set_block_count(13'd4096);
      send_item(OP_ALLOC, 12'd0);
      send_item(OP_FREE, 12'd4095);
      send_item(OP_FREE, 12'd0);
   endtask

   task automatic test_small_pools();
      set_block_count(13'd3);
      run_random(60, 60);
      set_block_count(13'd7);
      run_random(80, 60);
      set_block_count(13'd64);
      run_random(150, 72);
      run_random(50, 20);
   endtask

   task automatic test_word_boundary();
      set_block_count(13'd130);
      run_random(240, 75);
      // Shrinking the pool strands in-use blocks above the new limit.
      set_block_count(13'd70);
      run_random(60, 40);
   endtask

   task automatic test_full_rate();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      set_block_count(13'd4096);
      run_random(60, 50);
      wait_idle(0);
      run_random(60, 50);
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   task automatic test_oversize_count();
      set_block_count(COUNT_W'($urandom_range(4097, 8191)));
      run_random(80, 50);
      set_block_count(13'd0);
      run_random(10, 50);
      set_block_count(13'd1);
      run_random(20, 50);
   endtask

   initial begin
      busy_total     = '0;
      managed_blocks = BLOCK_COUNT_RESET;
      for (int b = 0; b < NUM_BLOCKS; b++) block_busy[b] = 1'b0;
      for (int s = 0; s < 4; s++) status_seen[s] = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_small_pools();
      test_word_boundary();
      test_full_rate();
      test_oversize_count();

      wait_idle(DRAIN_CYCLES);
      $display("Covered %0d requests under %0d block-count writes, from zero up to 8191.",
               items_sent, settings_used);
      $display("Replies: %0d ok, %0d out of blocks, %0d already free, %0d out of range.",
               status_seen[STATUS_OK], status_seen[STATUS_FULL],
               status_seen[STATUS_ALREADY_FREE], status_seen[STATUS_RANGE]);
      if (fail_count == 0 && outcomes_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/block_bitmap_allocator_unit.sv
tb/block_bitmap_allocator_unit_test.sv
